// ----- sv/pawq_pkg.sv -----
// Shared types, constants and helper functions for the admission wait queue.
package pawq_pkg;

  localparam int PRIO_DEPTH_DEF   = 16;
  localparam int NORMAL_DEPTH_DEF = 32;

  typedef struct packed {
    logic [31:0] client_id;
    logic        is_premium;
    logic        always_allowed;
    logic [15:0] players_online;
    logic [47:0] now_ms;
  } req_t;

  typedef struct packed {
    logic       admitted;
    logic [5:0] queue_slot;
    logic [6:0] retry_seconds;
    logic       queue_full;
  } res_t;

  // One stored queue entry
  typedef struct packed {
    logic [31:0] id;
    logic [47:0] expiry;
  } entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic init;
    logic purge;
    logic fin;
    logic q;
    logic shift_init;
    logic shift;
    logic drop;
    logic refresh;
    logic append;
    logic emit;
    logic emit_admit;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic quick;
    logic scan_end;
    logic found;
    logic fits;
  } stat_t;

  // Retry tier for a 1-based slot
  function automatic logic [6:0] tier_of(input logic [31:0] s);
    logic [6:0] t;
    if (s < 32'd5) t = 7'd5;
    else if (s < 32'd10) t = 7'd10;
    else if (s < 32'd20) t = 7'd20;
    else if (s < 32'd50) t = 7'd60;
    else t = 7'd120;
    return t;
  endfunction

  // Hold time in ms for a tier: (tier + 15) * 1000
  function automatic logic [17:0] hold_ms(input logic [6:0] t);
    logic [17:0] h;
    case (t)
      7'd5:    h = 18'd20000;
      7'd10:   h = 18'd25000;
      7'd20:   h = 18'd35000;
      7'd60:   h = 18'd75000;
      default: h = 18'd135000;
    endcase
    return h;
  endfunction

endpackage

// ----- sv/priority_admission_wait_queue.sv -----
// Top level of the login admission gate with priority and normal wait queues.
//
//  channel   ports                  transfer
//  request   start, busy, req       start high and busy low at a clock edge
//  result    done, res              done high for one cycle; always taken
//  config    cfg_we, cfg_data       cfg_we high at a clock edge
//
// A request admitted at once has its result emitted from the check state.
// Otherwise both queues are purged in turn and a decision follows;
// admitting a queued client adds a shift pass over the entries behind it.
// Each pass reads one entry per cycle through the single read port of its
// queue memory.
// Reset clears the limit and both queue counts; no clearing pass is needed.
// The result receiver cannot stall; busy falls as done rises.
module priority_admission_wait_queue #(
  parameter int PRIO_DEPTH   = pawq_pkg::PRIO_DEPTH_DEF,
  parameter int NORMAL_DEPTH = pawq_pkg::NORMAL_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_data,
  input  logic            start,
  output logic            busy,
  input  pawq_pkg::req_t  req,
  output logic            done,
  output pawq_pkg::res_t  res
);

  pawq_pkg::cmd_t  cmd;
  pawq_pkg::stat_t st;

  pawq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  pawq_dp #(.PRIO_DEPTH(PRIO_DEPTH), .NORMAL_DEPTH(NORMAL_DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .cmd      (cmd),
    .st       (st),
    .done     (done),
    .res      (res)
  );

endmodule

// ----- sv/pawq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pawq_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [0:D-1];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/pawq_ctrl.sv -----
// Sequencer for one login request: check, purge both queues, decide, and shift when a queued client is admitted.
module pawq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pawq_pkg::stat_t st,
  output pawq_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_PURP  = 3'd2;
  localparam logic [2:0] S_PURN  = 3'd3;
  localparam logic [2:0] S_DEC   = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;

  logic [2:0] state, state_next;

  assign busy = (state != S_IDLE);

  // Decode state into datapath commands and the next state
  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.quick) begin
          cmd.emit = 1'b1;
          cmd.emit_admit = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.init = 1'b1;
          state_next = S_PURP;
        end
      end
      S_PURP: begin
        cmd.purge = 1'b1;
        if (st.scan_end) begin
          cmd.fin = 1'b1;
          cmd.init = 1'b1;
          state_next = S_PURN;
        end
      end
      S_PURN: begin
        cmd.purge = 1'b1;
        cmd.q = 1'b1;
        if (st.scan_end) begin
          cmd.fin = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (st.found && st.fits) begin
          cmd.shift_init = 1'b1;
          state_next = S_SHIFT;
        end else begin
          cmd.refresh = st.found;
          cmd.append = !st.found;
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (st.scan_end) begin
          cmd.drop = 1'b1;
          cmd.emit = 1'b1;
          cmd.emit_admit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/pawq_dp.sv -----
// Datapath: queue memories, counts, scan pointers, match search and result.
module pawq_dp #(
  parameter int PRIO_DEPTH   = pawq_pkg::PRIO_DEPTH_DEF,
  parameter int NORMAL_DEPTH = pawq_pkg::NORMAL_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  pawq_pkg::req_t    req,
  input  pawq_pkg::cmd_t    cmd,
  output pawq_pkg::stat_t   st,
  output logic              done,
  output pawq_pkg::res_t    res
);

  localparam int PA   = (PRIO_DEPTH > 1) ? $clog2(PRIO_DEPTH) : 1;
  localparam int NA   = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
  localparam int MAXD = (PRIO_DEPTH > NORMAL_DEPTH) ? PRIO_DEPTH : NORMAL_DEPTH;
  localparam int RW   = $clog2(MAXD + 1);
  localparam int PCW  = $clog2(PRIO_DEPTH + 1);
  localparam int NCW  = $clog2(NORMAL_DEPTH + 1);
  localparam int SW   = $clog2(PRIO_DEPTH + NORMAL_DEPTH + 2);

  logic [15:0]     maxp;
  pawq_pkg::req_t  cur;
  logic [PCW-1:0]  pcnt;
  logic [NCW-1:0]  ncnt;
  logic [RW-1:0]   r, w, rq, pos;
  logic            rv;
  logic            found, where_q;
  logic [SW-1:0]   slot;

  pawq_pkg::entry_t p_rd, n_rd, rd, wdata;
  logic            sel, keep, hit, fits, full, wen, wq;
  logic [RW-1:0]   cnt, waddr;
  logic [SW-1:0]   base, newslot, oslot;
  logic [SW+5:0]   oslot_ext;
  logic [6:0]      tier;
  logic [48:0]     esum;
  logic [47:0]     expv;

  // Select the queue under scan and test the entry coming out of it
  assign sel  = cmd.shift ? where_q : cmd.q;
  assign cnt  = sel ? RW'(ncnt) : RW'(pcnt);
  assign rd   = sel ? n_rd : p_rd;
  assign keep = rd.expiry > cur.now_ms;
  assign hit  = rd.id == cur.client_id;
  assign base = sel ? SW'(pcnt) : '0;

  // Decision terms
  assign fits = ({1'b0, cur.players_online} + 17'(slot)) <= {1'b0, maxp};
  assign newslot = cur.is_premium ? (SW'(pcnt) + SW'(1))
                                  : (SW'(pcnt) + SW'(ncnt) + SW'(1));
  assign full = cur.is_premium ? (pcnt >= PCW'(PRIO_DEPTH))
                               : (ncnt >= NCW'(NORMAL_DEPTH));
  assign oslot = found ? slot : newslot;
  assign oslot_ext = {6'd0, oslot};
  assign tier = pawq_pkg::tier_of(32'(oslot));
  assign esum = {1'b0, cur.now_ms} + 49'(pawq_pkg::hold_ms(tier));
  assign expv = esum[48] ? '1 : esum[47:0];

  assign st.quick = cur.always_allowed || (maxp == 16'd0) ||
                    ((pcnt == '0) && (ncnt == '0) && (cur.players_online < maxp));
  assign st.scan_end = (r >= cnt) && !rv;
  assign st.found = found;
  assign st.fits = fits;

  // Pick the one write of this cycle
  always_comb begin
    wen = 1'b0;
    wq = sel;
    waddr = w;
    wdata = rd;
    if (cmd.purge && rv && keep) begin
      wen = 1'b1;
    end else if (cmd.shift && rv) begin
      wen = 1'b1;
      waddr = rq - RW'(1);
    end else if (cmd.refresh) begin
      wen = 1'b1;
      wq = where_q;
      waddr = pos;
      wdata = '{id: cur.client_id, expiry: expv};
    end else if (cmd.append && !full) begin
      wen = 1'b1;
      wq = !cur.is_premium;
      waddr = cur.is_premium ? RW'(pcnt) : RW'(ncnt);
      wdata = '{id: cur.client_id, expiry: expv};
    end
  end

  pawq_ram #(.W($bits(pawq_pkg::entry_t)), .D(PRIO_DEPTH)) u_prio (
    .clk   (clk),
    .we    (wen && !wq),
    .waddr (waddr[PA-1:0]),
    .wdata (wdata),
    .raddr (r[PA-1:0]),
    .rdata (p_rd)
  );

  pawq_ram #(.W($bits(pawq_pkg::entry_t)), .D(NORMAL_DEPTH)) u_norm (
    .clk   (clk),
    .we    (wen && wq),
    .waddr (waddr[NA-1:0]),
    .wdata (wdata),
    .raddr (r[NA-1:0]),
    .rdata (n_rd)
  );

  // Control registers: limit, counts, scan pointers, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      maxp <= '0;
      pcnt <= '0;
      ncnt <= '0;
      rv <= 1'b0;
      r <= '0;
      w <= '0;
      done <= 1'b0;
    end else begin
      if (cfg_we) begin
        maxp <= cfg_data;
      end
      done <= cmd.emit;
      // Restart or stream reads one entry per cycle
      if (cmd.init) begin
        r <= '0;
        w <= '0;
        rv <= 1'b0;
      end else if (cmd.shift_init) begin
        r <= pos + RW'(1);
        rv <= 1'b0;
      end else begin
        if (cmd.purge || cmd.shift) begin
          if (r < cnt) begin
            rv <= 1'b1;
            r <= r + RW'(1);
          end else begin
            rv <= 1'b0;
          end
        end
        if (cmd.purge && rv && keep) begin
          w <= w + RW'(1);
        end
      end
      if (cmd.fin) begin
        if (cmd.q) begin
          ncnt <= NCW'(w);
        end else begin
          pcnt <= PCW'(w);
        end
      end
      if (cmd.drop) begin
        if (where_q) begin
          ncnt <= ncnt - NCW'(1);
        end else begin
          pcnt <= pcnt - PCW'(1);
        end
      end
      if (cmd.append && !full) begin
        if (cur.is_premium) begin
          pcnt <= pcnt + PCW'(1);
        end else begin
          ncnt <= ncnt + NCW'(1);
        end
      end
    end
  end

  // Payload registers: request, match, result
  always_ff @(posedge clk) begin
    rq <= r;
    if (cmd.load) begin
      cur <= req;
      found <= 1'b0;
    end
    // Record the first surviving match in queue order
    if (cmd.purge && rv && keep && !found && hit) begin
      found <= 1'b1;
      where_q <= sel;
      pos <= w;
      slot <= base + SW'(w) + SW'(1);
    end
    if (cmd.emit) begin
      res.admitted <= cmd.emit_admit;
      res.queue_slot <= (cmd.emit_admit || (cmd.append && full)) ? 6'd0
                                                                 : oslot_ext[5:0];
      res.retry_seconds <= cmd.emit_admit ? 7'd0 : tier;
      res.queue_full <= cmd.append && full;
    end
  end

endmodule

// ----- sim/tb_priority_admission_wait_queue.sv -----
// Self-checking testbench for the priority admission wait queue.
module tb_priority_admission_wait_queue;

  localparam int PD = pawq_pkg::PRIO_DEPTH_DEF;
  localparam int ND = pawq_pkg::NORMAL_DEPTH_DEF;
  localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int WATCHDOG = 5000;

  // Admission predictor and the queue of expected results
  class admission_board;
    logic [31:0] pid[PD];
    logic [47:0] pexp[PD];
    int pcnt;
    logic [31:0] nid[ND];
    logic [47:0] nexp[ND];
    int ncnt;
    logic [15:0] limit;
    pawq_pkg::res_t pending[$];
    int errors;

    function new();
      pcnt = 0; ncnt = 0; limit = 0; errors = 0;
    endfunction

    function logic [6:0] tier(int s);
      if (s < 5) return 7'd5;
      if (s < 10) return 7'd10;
      if (s < 20) return 7'd20;
      if (s < 50) return 7'd60;
      return 7'd120;
    endfunction

    function logic [47:0] expiry(logic [47:0] now, int s);
      logic [48:0] e;
      e = {1'b0, now} + 49'((tier(s) + 15) * 1000);
      return (e > {1'b0, T_MAX}) ? T_MAX : e[47:0];
    endfunction

    // Note one accepted request and predict its result
    function void note_request(pawq_pkg::req_t r);
      pawq_pkg::res_t o;
      int w, slot, where, pos;
      o = '0;
      where = 0; pos = 0;
      if (r.always_allowed || limit == 0 ||
          (pcnt == 0 && ncnt == 0 && r.players_online < limit)) begin
        o.admitted = 1'b1;
        pending.push_back(o);
        return;
      end
      // drop expired entries, keeping order
      w = 0;
      for (int i = 0; i < pcnt; i++)
        if (pexp[i] > r.now_ms) begin
          pid[w] = pid[i]; pexp[w] = pexp[i]; w++;
        end
      pcnt = w;
      w = 0;
      for (int i = 0; i < ncnt; i++)
        if (nexp[i] > r.now_ms) begin
          nid[w] = nid[i]; nexp[w] = nexp[i]; w++;
        end
      ncnt = w;
      slot = 1;
      for (int i = 0; i < pcnt && where == 0; i++)
        if (pid[i] == r.client_id) begin
          where = 1; pos = i;
        end else slot++;
      for (int i = 0; i < ncnt && where == 0; i++)
        if (nid[i] == r.client_id) begin
          where = 2; pos = i;
        end else slot++;
      if (where != 0) begin
        if (int'(r.players_online) + slot <= int'(limit)) begin
          if (where == 1) begin
            for (int i = pos; i + 1 < pcnt; i++) begin
              pid[i] = pid[i+1]; pexp[i] = pexp[i+1];
            end
            pcnt--;
          end else begin
            for (int i = pos; i + 1 < ncnt; i++) begin
              nid[i] = nid[i+1]; nexp[i] = nexp[i+1];
            end
            ncnt--;
          end
          o.admitted = 1'b1;
        end else begin
          if (where == 1) pexp[pos] = expiry(r.now_ms, slot);
          else nexp[pos] = expiry(r.now_ms, slot);
          o.queue_slot = slot[5:0];
          o.retry_seconds = tier(slot);
        end
        pending.push_back(o);
        return;
      end
      if (r.is_premium) begin
        slot = pcnt + 1;
        o.retry_seconds = tier(slot);
        if (pcnt >= PD) o.queue_full = 1'b1;
        else begin
          pid[pcnt] = r.client_id; pexp[pcnt] = expiry(r.now_ms, slot); pcnt++;
          o.queue_slot = slot[5:0];
        end
      end else begin
        slot = pcnt + ncnt + 1;
        o.retry_seconds = tier(slot);
        if (ncnt >= ND) o.queue_full = 1'b1;
        else begin
          nid[ncnt] = r.client_id; nexp[ncnt] = expiry(r.now_ms, slot); ncnt++;
          o.queue_slot = slot[5:0];
        end
      end
      pending.push_back(o);
    endfunction

    // Compare one result with the oldest prediction
    function void check_result(pawq_pkg::res_t a);
      pawq_pkg::res_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: %p", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.admitted !== e.admitted) begin
        $error("admitted: expected %0d actual %0d", e.admitted, a.admitted); errors++;
      end
      if (a.queue_slot !== e.queue_slot) begin
        $error("queue_slot: expected %0d actual %0d", e.queue_slot, a.queue_slot); errors++;
      end
      if (a.retry_seconds !== e.retry_seconds) begin
        $error("retry_seconds: expected %0d actual %0d", e.retry_seconds,
               a.retry_seconds);
        errors++;
      end
      if (a.queue_full !== e.queue_full) begin
        $error("queue_full: expected %0d actual %0d", e.queue_full, a.queue_full); errors++;
      end
    endfunction
  endclass

  logic clk, rst, cfg_we, start, busy, done;
  logic [15:0] cfg_data;
  pawq_pkg::req_t req;
  pawq_pkg::res_t res;

  priority_admission_wait_queue dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .req(req), .done(done), .res(res)
  );

  admission_board board = new();
  int sender_idle;
  int quiet_cycles;
  int sent;
  logic [47:0] clock_ms;
  logic [31:0] ids[8];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Check every result strobe and watch for a stalled run
  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_result(res);
      if (done || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("timeout with %0d results outstanding", board.pending.size());
        $display("priority_admission_wait_queue: mismatch");
        $finish;
      end
    end
  end

  // Transfer one request, idling first at the current rate
  task automatic send_request(pawq_pkg::req_t r);
    @(posedge clk);
    while ($urandom_range(99) < sender_idle) @(posedge clk);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(r);
    sent++;
    start <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.limit = v;
  endtask

  function automatic pawq_pkg::req_t make_req(logic [31:0] id, bit prem, bit byp,
                                              logic [15:0] online, logic [47:0] now);
    pawq_pkg::req_t r;
    r.client_id = id; r.is_premium = prem; r.always_allowed = byp;
    r.players_online = online; r.now_ms = now;
    return r;
  endfunction

  // Random request from a small id pool so clients come back to their slot
  function automatic pawq_pkg::req_t random_req();
    logic [31:0] id;
    logic [15:0] on;
    if ($urandom_range(9) == 0) id = $urandom();
    else id = ids[$urandom_range(7)] + $urandom_range(7);
    clock_ms = clock_ms + $urandom_range(4000);
    if ($urandom_range(15) == 0) on = 16'($urandom());
    else on = 16'(board.limit - $urandom_range(40));
    return make_req(id, $urandom_range(2) == 0, $urandom_range(15) == 0, on,
                    ($urandom_range(30) == 0) ? 48'($urandom()) << 16 | $urandom()
                                              : clock_ms);
  endfunction

  initial begin
    rst = 1'b1; cfg_we = 1'b0; cfg_data = '0; start = 1'b0; req = '0;
    sender_idle = 29; quiet_cycles = 0; sent = 0; clock_ms = 48'd1000;
    for (int i = 0; i < 8; i++) ids[i] = $urandom() & 32'hFFFF_FF00 | (i * 32);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero limit, bypass, quick admit, fill queues, overflow, saturated time
    send_request(make_req(32'hFFFF_FFFF, 1, 0, 16'hFFFF, T_MAX));
    set_limit(16'd10);
    send_request(make_req(32'd0, 0, 0, 16'd0, 48'd0));
    send_request(make_req(32'd1, 0, 1, 16'hFFFF, 48'd5));
    send_request(make_req(32'd2, 0, 0, 16'd10, 48'd10));
    send_request(make_req(32'd3, 1, 0, 16'd10, 48'd20));
    send_request(make_req(32'd2, 0, 0, 16'd10, 48'd30));
    send_request(make_req(32'd2, 0, 0, 16'd7, 48'd40));
    send_request(make_req(32'd3, 1, 0, 16'd9, 48'd50));
    for (int i = 0; i < 18; i++)
      send_request(make_req(32'd100 + i, 1, 0, 16'd200, 48'd100));
    for (int i = 0; i < 34; i++)
      send_request(make_req(32'd200 + i, 0, 0, 16'd200, 48'd100));
    send_request(make_req(32'd205, 0, 0, 16'd0, 48'd200));
    send_request(make_req(32'd300, 0, 0, 16'd200, 48'd10_000_000));
    send_request(make_req(32'd301, 1, 0, 16'd200, T_MAX - 48'd3));
    send_request(make_req(32'd301, 1, 0, 16'd200, T_MAX - 48'd2));
    set_limit(16'hFFFF);
    send_request(make_req(32'd302, 0, 0, 16'hFFFF, T_MAX - 48'd1));
    send_request(make_req(32'd303, 1, 0, 16'hFFFF, T_MAX));

    // Random phases over several limits and idle patterns
    for (int ph = 0; ph < 9; ph++) begin
      sender_idle = (ph < 3) ? 29 : (ph < 6) ? 48 : 0;
      case (ph % 3)
        0: set_limit(16'(1 + $urandom_range(60)));
        1: set_limit(16'($urandom()));
        default: set_limit((ph == 8) ? 16'hFFFF : 16'd1);
      endcase
      clock_ms = (ph == 4) ? T_MAX - 48'd200000 : clock_ms;
      for (int k = 0; k < 43; k++) begin
        if (ph == 5 && k == 25) drain();
        send_request(random_req());
      end
    end
    set_limit(16'd0);
    send_request(random_req());

    drain();
    $display("run covered %0d requests over zero, small, random and full limits,", sent);
    $display("bypass, queue overflow, expiry and saturated time with varied idling");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("priority_admission_wait_queue: match");
    else
      $display("priority_admission_wait_queue: mismatch");
    $finish;
  end
endmodule
